// ----- src/rvd_pkg.sv -----
// ----------------------------------------------------------------------------
// RTP video depacketizer package
// Shared types, codes and constants of the depacketizer.
// ----------------------------------------------------------------------------
`default_nettype none

package rvd_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int JOB_BYTES   = 6;

  typedef enum logic [1:0] {
    MODE_H264 = 2'd0,
    MODE_H265 = 2'd1,
    MODE_PASS = 2'd2,
    MODE_LEN  = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    PH_START  = 4'd0,
    PH_AGGHDR = 4'd1,
    PH_SIZE   = 4'd2,
    PH_UNIT   = 4'd3,
    PH_FUHDR  = 4'd4,
    PH_SKIP   = 4'd5,
    PH_COPY   = 4'd6,
    PH_DROP   = 4'd7,
    PH_H5B1   = 4'd8,
    PH_H5FUH  = 4'd9
  } phase_t;

  // H.264 NAL unit types that carry packetization structure.
  localparam logic [4:0] NAL_STAP_A  = 5'd24;
  localparam logic [4:0] NAL_STAP_B  = 5'd25;
  localparam logic [4:0] NAL_MTAP16  = 5'd26;
  localparam logic [4:0] NAL_MTAP24  = 5'd27;
  localparam logic [4:0] NAL_FU_A    = 5'd28;
  localparam logic [4:0] NAL_FU_B    = 5'd29;
  // H.265 NAL unit types.
  localparam logic [5:0] HEVC_AP     = 6'd48;
  localparam logic [5:0] HEVC_FU     = 6'd49;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        packet_end;
    logic [15:0] packet_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_item_t;

  // Bytes produced by one input byte; bytes[0] goes out first.
  typedef struct packed {
    logic [2:0]                 count;
    logic [JOB_BYTES-1:0][7:0]  bytes;
  } job_t;

endpackage

`default_nettype wire

// ----- src/rvd_front.sv -----
// ----------------------------------------------------------------------------
// RTP video depacketizer front end
// Parses payload bytes and turns each into a job of zero to six output bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module rvd_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_accept,
  input  wire rvd_pkg::in_item_t in_item,
  input  wire logic            cfg_write,
  input  wire logic [1:0]      cfg_value,
  output rvd_pkg::job_t        job,
  output logic                 job_valid
);
  import rvd_pkg::*;

  mode_t       mode_r;
  phase_t      phase_r, phase_nxt;
  logic [2:0]  hc_r, hc_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [5:0]  kind_r, kind_nxt;
  logic [7:0]  held_first_r, held_first_nxt;
  logic [7:0]  held_second_r, held_second_nxt;
  logic [7:0]  size_high_r, size_high_nxt;

  logic [7:0]  b;
  logic [2:0]  hdr_last;
  logic [2:0]  hc_dec;
  logic [15:0] rem_dec;
  logic        fu_start;

  assign b        = in_item.payload_byte;
  assign hc_dec   = hc_r - 3'd1;
  assign rem_dec  = rem_r - 16'd1;
  assign fu_start = b[7] & ~b[6];

  // Last header byte index of an aggregation unit: MTAP units carry DOND
  // and a timestamp offset after the size.
  always_comb begin
    if (kind_r == {1'b0, NAL_MTAP16}) begin
      hdr_last = 3'd4;
    end else if (kind_r == {1'b0, NAL_MTAP24}) begin
      hdr_last = 3'd5;
    end else begin
      hdr_last = 3'd1;
    end
  end

  always_comb begin
    phase_nxt       = phase_r;
    hc_nxt          = hc_r;
    rem_nxt         = rem_r;
    kind_nxt        = kind_r;
    held_first_nxt  = held_first_r;
    held_second_nxt = held_second_r;
    size_high_nxt   = size_high_r;
    job             = '0;
    job.bytes[3]    = 8'h01;

    case (phase_r)
      PH_START: begin
        case (mode_r)
          MODE_H264: begin
            kind_nxt = {1'b0, b[4:0]};
            if (b[4:0] == NAL_STAP_A) begin
              phase_nxt = PH_SIZE;
              hc_nxt    = 3'd0;
            end else if (b[4:0] == NAL_STAP_B || b[4:0] == NAL_MTAP16 ||
                         b[4:0] == NAL_MTAP24) begin
              phase_nxt = PH_AGGHDR;
              hc_nxt    = 3'd2;
            end else if (b[4:0] == NAL_FU_A || b[4:0] == NAL_FU_B) begin
              held_first_nxt = b;
              phase_nxt      = PH_FUHDR;
            end else begin
              job.count    = 3'd5;
              job.bytes[4] = b;
              phase_nxt    = PH_COPY;
            end
          end
          MODE_H265: begin
            kind_nxt = b[6:1];
            if (b[6:1] == HEVC_AP) begin
              phase_nxt = PH_DROP;
            end else if (b[6:1] == HEVC_FU) begin
              held_first_nxt = b;
              phase_nxt      = PH_H5B1;
            end else begin
              job.count    = 3'd5;
              job.bytes[4] = b;
              phase_nxt    = PH_COPY;
            end
          end
          MODE_LEN: begin
            job.count    = 3'd5;
            job.bytes[0] = in_item.packet_length[7:0];
            job.bytes[1] = in_item.packet_length[15:8];
            job.bytes[2] = 8'h00;
            job.bytes[3] = 8'h00;
            job.bytes[4] = b;
            phase_nxt    = PH_COPY;
          end
          default: begin
            job.count    = 3'd1;
            job.bytes[0] = b;
            phase_nxt    = PH_COPY;
          end
        endcase
      end
      PH_AGGHDR: begin
        hc_nxt = hc_dec;
        if (hc_dec == 3'd0) begin
          phase_nxt = PH_SIZE;
        end
      end
      PH_SIZE: begin
        if (hc_r == 3'd0) begin
          size_high_nxt = b;
        end else if (hc_r == 3'd1) begin
          rem_nxt = {size_high_r, b};
        end
        if (hc_r >= hdr_last) begin
          job.count = 3'd4;
          hc_nxt    = 3'd0;
          if (rem_nxt != 16'd0) begin
            phase_nxt = PH_UNIT;
          end
        end else begin
          hc_nxt = hc_r + 3'd1;
        end
      end
      PH_UNIT: begin
        job.count    = 3'd1;
        job.bytes[0] = b;
        rem_nxt      = rem_dec;
        if (rem_dec == 16'd0) begin
          phase_nxt = PH_SIZE;
          hc_nxt    = 3'd0;
        end
      end
      PH_FUHDR: begin
        if (fu_start) begin
          job.count    = 3'd5;
          job.bytes[4] = {held_first_r[7:5], b[4:0]};
        end
        if (kind_r == {1'b0, NAL_FU_B}) begin
          if (fu_start) begin
            phase_nxt = PH_SKIP;
            hc_nxt    = 3'd2;
          end else begin
            phase_nxt = PH_DROP;
          end
        end else begin
          phase_nxt = PH_COPY;
        end
      end
      PH_SKIP: begin
        hc_nxt = hc_dec;
        if (hc_dec == 3'd0) begin
          phase_nxt = PH_COPY;
        end
      end
      PH_COPY: begin
        job.count    = 3'd1;
        job.bytes[0] = b;
      end
      PH_H5B1: begin
        held_second_nxt = b;
        phase_nxt       = PH_H5FUH;
      end
      PH_H5FUH: begin
        if (fu_start) begin
          job.count    = 3'd6;
          job.bytes[4] = {held_first_r[7], b[5:0], held_first_r[0]};
          job.bytes[5] = held_second_r;
        end
        phase_nxt = PH_COPY;
      end
      default: begin
      end
    endcase

    if (in_item.packet_end) begin
      phase_nxt       = PH_START;
      hc_nxt          = 3'd0;
      rem_nxt         = 16'd0;
      kind_nxt        = 6'd0;
      held_first_nxt  = 8'd0;
      held_second_nxt = 8'd0;
      size_high_nxt   = 8'd0;
    end
  end

  assign job_valid = in_accept && (job.count != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_write) begin
      phase_r       <= PH_START;
      hc_r          <= 3'd0;
      rem_r         <= 16'd0;
      kind_r        <= 6'd0;
      held_first_r  <= 8'd0;
      held_second_r <= 8'd0;
      size_high_r   <= 8'd0;
    end else if (in_accept) begin
      phase_r       <= phase_nxt;
      hc_r          <= hc_nxt;
      rem_r         <= rem_nxt;
      kind_r        <= kind_nxt;
      held_first_r  <= held_first_nxt;
      held_second_r <= held_second_nxt;
      size_high_r   <= size_high_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_H264;
    end else if (cfg_write) begin
      mode_r <= mode_t'(cfg_value);
    end
  end

endmodule

`default_nettype wire

// ----- src/rvd_queue.sv -----
// ----------------------------------------------------------------------------
// RTP video depacketizer job queue
// Short FIFO of output jobs between the parser and the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module rvd_queue #(
  parameter int Depth = rvd_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire rvd_pkg::job_t wr_job,
  output logic               full,
  input  wire logic          rd_en,
  output rvd_pkg::job_t      rd_job,
  output logic               empty
);
  import rvd_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);
  localparam logic [PtrW-1:0] PtrOne = PtrW'(1);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  job_t            mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] cnt_r;
  logic            do_wr, do_rd;

  assign full   = (cnt_r == DepthCnt);
  assign empty  = (cnt_r == '0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + PtrOne;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + PtrOne;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + CntOne;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - CntOne;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/rvd_back.sv -----
// ----------------------------------------------------------------------------
// RTP video depacketizer back end
// Serializes queued jobs into the output byte stream, one byte per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module rvd_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire rvd_pkg::job_t   q_job,
  input  wire logic            q_empty,
  output logic                 q_rd,
  output logic                 empty,
  input  wire logic            pop,
  output rvd_pkg::out_item_t   out_data
);
  import rvd_pkg::*;

  logic [JOB_BYTES-1:0][7:0] bytes_r;
  logic [2:0]                left_r;
  logic                      take;
  logic                      finish;

  assign empty             = (left_r == 3'd0);
  assign take              = pop && !empty;
  assign finish            = empty || (take && left_r == 3'd1);
  assign q_rd              = finish && !q_empty;
  assign out_data.out_byte = bytes_r[0];
  assign out_data.run_last = (left_r == 3'd1);

  always_ff @(posedge clk) begin
    if (q_rd) begin
      bytes_r <= q_job.bytes;
    end else if (take) begin
      bytes_r <= {8'h00, bytes_r[JOB_BYTES-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= 3'd0;
    end else if (q_rd) begin
      left_r <= q_job.count;
    end else if (take) begin
      left_r <= left_r - 3'd1;
    end
  end

endmodule

`default_nettype wire

// ----- src/rtp_video_depacketizer_top.sv -----
// ----------------------------------------------------------------------------
// RTP video depacketizer
// Turns RTP H.264/H.265 payload bytes into an Annex-B byte stream; in the other
// modes it passes bytes through or puts a length field before each packet.
// The parser takes one payload byte per cycle while the queue is not full and
// turns it into zero to six stream bytes, which wait in a queue of QueueDepth
// entries; the serializer sends one stream byte per cycle while pop is high.
// A byte that yields several stream bytes holds the output longer, so input is
// taken every cycle until the queue fills, and start-code bursts stall it
// briefly. A mode write on cfg_data also resets the parser to a packet start.
`default_nettype none

module rtp_video_depacketizer_top #(
  parameter int QueueDepth = rvd_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire rvd_pkg::in_item_t  in_data,
  output logic                    empty,
  input  wire logic               pop,
  output rvd_pkg::out_item_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_data
);
  import rvd_pkg::*;

  job_t front_job, q_job;
  logic front_valid, q_empty, q_rd, accept;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  rvd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (accept),
    .in_item   (in_data),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_value (cfg_data),
    .job       (front_job),
    .job_valid (front_valid)
  );

  rvd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (front_valid),
    .wr_job (front_job),
    .full   (full),
    .rd_en  (q_rd),
    .rd_job (q_job),
    .empty  (q_empty)
  );

  rvd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_job    (q_job),
    .q_empty  (q_empty),
    .q_rd     (q_rd),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP video depacketizer testbench
// Feeds RTP payload packets in every payload mode and compares the output
// byte stream with a predictor that tracks the packet parser.
// The phases mix sender idles and receiver stalls in several combinations.
// ----------------------------------------------------------------------------
module tb_top;
  import rvd_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int NUM_PHASES   = 8;

  logic       clk;
  logic       rst_n;
  logic       push;
  logic       full;
  in_item_t   in_data;
  logic       empty;
  logic       pop;
  out_item_t  out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_data;

  rtp_video_depacketizer_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Payload bytes waiting to be pushed, and the stream bytes still owed.
  in_item_t   pend_items[$];
  out_item_t  stream_exp[$];
  logic [7:0] step_bytes[$];
  logic [7:0] pkt[$];

  int  send_idle_pct;
  int  pop_stall_pct;
  int  queued_items;
  int  err_count;
  int  cycle_count;
  int  result_idx;
  bit  in_stuck;
  bit  cfg_written;
  out_item_t want;

  // Parser state of the predictor.
  mode_t      dp_mode;
  phase_t     dp_phase;
  logic [2:0] dp_hdr;
  logic [15:0] dp_left;
  logic [5:0] dp_kind;
  logic [7:0] dp_first;
  logic [7:0] dp_second;
  logic [7:0] dp_size_hi;

  task automatic log_mismatch(input string msg);
    err_count++;
    if (err_count <= 40) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
  endtask

  function automatic void depack_clear();
    dp_phase   = PH_START;
    dp_hdr     = '0;
    dp_left    = '0;
    dp_kind    = '0;
    dp_first   = '0;
    dp_second  = '0;
    dp_size_hi = '0;
  endfunction

  function automatic void depack_set_mode(input mode_t m);
    dp_mode = m;
    depack_clear();
  endfunction

  function automatic void put_start_code();
    step_bytes.push_back(8'h00);
    step_bytes.push_back(8'h00);
    step_bytes.push_back(8'h00);
    step_bytes.push_back(8'h01);
  endfunction

  // Works out the stream bytes that one payload byte produces.
  function automatic void depack_byte(input in_item_t it);
    logic [7:0] b;
    logic [5:0] t;
    logic [2:0] last_hdr;
    bit         fu_start;
    out_item_t  o;
    b = it.payload_byte;
    step_bytes.delete();
    case (dp_phase)
      PH_START: begin
        if (dp_mode == MODE_H264) begin
          dp_kind = {1'b0, b[4:0]};
          if (b[4:0] == NAL_STAP_A) begin
            dp_phase = PH_SIZE;
            dp_hdr   = 3'd0;
          end else if (b[4:0] == NAL_STAP_B || b[4:0] == NAL_MTAP16 ||
                       b[4:0] == NAL_MTAP24) begin
            dp_phase = PH_AGGHDR;
            dp_hdr   = 3'd2;
          end else if (b[4:0] == NAL_FU_A || b[4:0] == NAL_FU_B) begin
            dp_first = b;
            dp_phase = PH_FUHDR;
          end else begin
            put_start_code();
            step_bytes.push_back(b);
            dp_phase = PH_COPY;
          end
        end else if (dp_mode == MODE_H265) begin
          t = b[6:1];
          dp_kind = t;
          if (t == HEVC_AP) begin
            dp_phase = PH_DROP;
          end else if (t == HEVC_FU) begin
            dp_first = b;
            dp_phase = PH_H5B1;
          end else begin
            put_start_code();
            step_bytes.push_back(b);
            dp_phase = PH_COPY;
          end
        end else begin
          if (dp_mode == MODE_LEN) begin
            step_bytes.push_back(it.packet_length[7:0]);
            step_bytes.push_back(it.packet_length[15:8]);
            step_bytes.push_back(8'h00);
            step_bytes.push_back(8'h00);
          end
          step_bytes.push_back(b);
          dp_phase = PH_COPY;
        end
      end
      PH_AGGHDR: begin
        dp_hdr = dp_hdr - 3'd1;
        if (dp_hdr == 3'd0) dp_phase = PH_SIZE;
      end
      PH_SIZE: begin
        if (dp_hdr == 3'd0) dp_size_hi = b;
        else if (dp_hdr == 3'd1) dp_left = {dp_size_hi, b};
        // MTAP units carry DOND and a timestamp offset after the size.
        if (dp_kind == 6'(NAL_MTAP16)) last_hdr = 3'd4;
        else if (dp_kind == 6'(NAL_MTAP24)) last_hdr = 3'd5;
        else last_hdr = 3'd1;
        if (dp_hdr >= last_hdr) begin
          put_start_code();
          dp_hdr = 3'd0;
          if (dp_left != 16'd0) dp_phase = PH_UNIT;
        end else begin
          dp_hdr = dp_hdr + 3'd1;
        end
      end
      PH_UNIT: begin
        step_bytes.push_back(b);
        dp_left = dp_left - 16'd1;
        if (dp_left == 16'd0) begin
          dp_phase = PH_SIZE;
          dp_hdr   = 3'd0;
        end
      end
      PH_FUHDR: begin
        fu_start = b[7] && !b[6];
        if (fu_start) begin
          put_start_code();
          step_bytes.push_back({dp_first[7:5], b[4:0]});
        end
        if (dp_kind == 6'(NAL_FU_B)) begin
          if (fu_start) begin
            dp_phase = PH_SKIP;
            dp_hdr   = 3'd2;
          end else begin
            dp_phase = PH_DROP;
          end
        end else begin
          dp_phase = PH_COPY;
        end
      end
      PH_SKIP: begin
        dp_hdr = dp_hdr - 3'd1;
        if (dp_hdr == 3'd0) dp_phase = PH_COPY;
      end
      PH_COPY: step_bytes.push_back(b);
      PH_H5B1: begin
        dp_second = b;
        dp_phase  = PH_H5FUH;
      end
      PH_H5FUH: begin
        if (b[7] && !b[6]) begin
          put_start_code();
          step_bytes.push_back({dp_first[7], b[5:0], dp_first[0]});
          step_bytes.push_back(dp_second);
        end
        dp_phase = PH_COPY;
      end
      default: ;
    endcase
    if (it.packet_end) depack_clear();
    for (int i = 0; i < step_bytes.size(); i++) begin
      o.out_byte = step_bytes[i];
      o.run_last = (i == step_bytes.size() - 1);
      stream_exp.push_back(o);
    end
  endfunction

  // ---- Packet building ----

  function automatic void add_random(input int n);
    for (int i = 0; i < n; i++) pkt.push_back(8'($urandom_range(255)));
  endfunction

  function automatic logic [7:0] fu_header();
    logic [7:0] h;
    h = 8'($urandom_range(255));
    if ($urandom_range(1) == 0) h[7:6] = 2'b10;
    return h;
  endfunction

  // Aggregation units: a 16-bit size, hdr_tail extra header bytes, data.
  function automatic void add_units(input int hdr_tail);
    int n_units;
    int sz;
    n_units = $urandom_range(1, 3);
    for (int u = 0; u < n_units; u++) begin
      sz = ($urandom_range(99) < 15) ? 0 : $urandom_range(1, 4);
      if ($urandom_range(99) < 5) sz = $urandom_range(5, 65535);
      pkt.push_back(8'(sz >> 8));
      pkt.push_back(8'(sz));
      add_random(hdr_tail);
      if (sz > 4) begin
        // Oversized unit: the packet ends inside it.
        add_random($urandom_range(0, 4));
        break;
      end
      add_random(sz);
    end
  endfunction

  function automatic void build_packet(input mode_t m);
    int sel;
    logic [7:0] hdr;
    pkt.delete();
    sel = $urandom_range(99);
    hdr = 8'($urandom_range(255));
    if (m == MODE_H264) begin
      if (sel < 12) begin
        add_random($urandom_range(1, 6));
      end else if (sel < 30) begin
        if (hdr[4:0] >= NAL_STAP_A && hdr[4:0] <= NAL_FU_B) hdr[4:0] = 5'($urandom_range(23));
        pkt.push_back(hdr);
        add_random($urandom_range(0, 5));
      end else if (sel < 45) begin
        hdr[4:0] = NAL_STAP_A;
        pkt.push_back(hdr);
        add_units(0);
      end else if (sel < 53) begin
        hdr[4:0] = NAL_STAP_B;
        pkt.push_back(hdr);
        add_random(2);
        add_units(0);
      end else if (sel < 63) begin
        hdr[4:0] = NAL_MTAP16;
        pkt.push_back(hdr);
        add_random(2);
        add_units(3);
      end else if (sel < 71) begin
        hdr[4:0] = NAL_MTAP24;
        pkt.push_back(hdr);
        add_random(2);
        add_units(4);
      end else if (sel < 88) begin
        hdr[4:0] = NAL_FU_A;
        pkt.push_back(hdr);
        pkt.push_back(fu_header());
        add_random($urandom_range(0, 5));
      end else begin
        hdr[4:0] = NAL_FU_B;
        pkt.push_back(hdr);
        pkt.push_back(fu_header());
        add_random(2);
        add_random($urandom_range(0, 5));
      end
    end else if (m == MODE_H265) begin
      if (sel < 12) begin
        add_random($urandom_range(1, 6));
      end else if (sel < 20) begin
        hdr[6:1] = HEVC_AP;
        pkt.push_back(hdr);
        add_random($urandom_range(0, 6));
      end else if (sel < 50) begin
        if (hdr[6:1] == HEVC_AP || hdr[6:1] == HEVC_FU) hdr[6:1] = 6'($urandom_range(47));
        pkt.push_back(hdr);
        add_random($urandom_range(1, 6));
      end else begin
        hdr[6:1] = HEVC_FU;
        pkt.push_back(hdr);
        add_random(1);
        pkt.push_back(fu_header());
        add_random($urandom_range(0, 5));
      end
    end else begin
      add_random($urandom_range(1, 8));
    end
  endfunction

  // Length field; negative lets send_packet use the sent size or a random one.
  function automatic int pick_length(input mode_t m);
    int sel;
    sel = $urandom_range(99);
    if (m != MODE_LEN || sel >= 30) return -1;
    if (sel < 10) return 0;
    if (sel < 20) return 65535;
    return $urandom_range(65535);
  endfunction

  function automatic void send_packet(input bit with_end, input int plen, input bit may_cut);
    in_item_t    it;
    int          n;
    logic [15:0] len_field;
    n = pkt.size();
    if (may_cut && n > 1 && $urandom_range(9) == 0) n = $urandom_range(1, n - 1);
    if (plen >= 0) len_field = 16'(plen);
    else if ($urandom_range(9) == 0) len_field = 16'($urandom_range(65535));
    else len_field = 16'(n);
    for (int i = 0; i < n; i++) begin
      it.payload_byte  = pkt[i];
      it.packet_end    = with_end && (i == n - 1);
      it.packet_length = len_field;
      pend_items.push_back(it);
    end
    queued_items += n;
  endfunction

  function automatic void add_directed(input mode_t m);
    case (m)
      MODE_H264: begin
        pkt = '{8'hFF, 8'h00};
        send_packet(1'b1, -1, 1'b0);
        // Zero-size unit gives a bare start code, then a one-byte unit.
        pkt = '{8'h18, 8'h00, 8'h00, 8'h00, 8'h01, 8'hAB};
        send_packet(1'b1, -1, 1'b0);
        // FU-A with start and end both set copies only its payload.
        pkt = '{8'h7C, 8'hC5, 8'h22};
        send_packet(1'b1, -1, 1'b0);
        // FU-B that is not a start is dropped.
        pkt = '{8'h3D, 8'h05, 8'h01};
        send_packet(1'b1, -1, 1'b0);
        // STAP-B cut short inside its header.
        pkt = '{8'h19, 8'h00};
        send_packet(1'b1, -1, 1'b0);
      end
      MODE_H265: begin
        pkt = '{8'h60, 8'h01, 8'h33};
        send_packet(1'b1, -1, 1'b0);
        pkt = '{8'h62, 8'h01, 8'h85, 8'h44};
        send_packet(1'b1, -1, 1'b0);
      end
      MODE_LEN: begin
        pkt = '{8'h11};
        send_packet(1'b1, 0, 1'b0);
        pkt = '{8'h22};
        send_packet(1'b1, 65535, 1'b0);
      end
      default: ;
    endcase
  endfunction

  // ---- Driver: inputs change on the falling edge ----

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_stuck) begin
        if (pend_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          push    <= 1'b1;
          in_data <= pend_items[0];
        end else begin
          push <= 1'b0;
        end
      end
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // ---- Monitor: every transaction is sampled on the rising edge ----

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      in_stuck = push && full;
      if (cfg_valid && cfg_ready) begin
        depack_set_mode(mode_t'(cfg_data));
        cfg_written = 1'b1;
      end
      if (push && !full) begin
        depack_byte(in_data);
        void'(pend_items.pop_front());
      end
      if (pop && !empty) begin
        if (stream_exp.size() == 0) begin
          log_mismatch($sformatf("unexpected byte %h", out_data.out_byte));
        end else begin
          want = stream_exp.pop_front();
          if (out_data.out_byte !== want.out_byte)
            log_mismatch($sformatf("result %0d out_byte %h, expected %h",
                                   result_idx, out_data.out_byte, want.out_byte));
          if (out_data.run_last !== want.run_last)
            log_mismatch($sformatf("result %0d run_last %b, expected %b",
                                   result_idx, out_data.run_last, want.run_last));
        end
        result_idx++;
      end
    end
  end

  // ---- Sequencing ----

  task automatic write_mode(input mode_t m);
    @(negedge clk);
    cfg_valid   <= 1'b1;
    cfg_data    <= m;
    cfg_written = 1'b0;
    do @(negedge clk); while (!cfg_written);
    cfg_valid <= 1'b0;
  endtask

  // Returns once every queued byte is in and every stream byte is out,
  // leaving time for bytes that produce nothing to clear the parser.
  task automatic wait_idle();
    while (pend_items.size() != 0 || stream_exp.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  mode_t phase_mode[NUM_PHASES];
  int    phase_send[NUM_PHASES];
  int    phase_stall[NUM_PHASES];
  int    phase_target[NUM_PHASES];

  initial begin
    rst_n         = 1'b0;
    push          = 1'b0;
    pop           = 1'b0;
    in_data       = '0;
    cfg_valid     = 1'b0;
    cfg_data      = MODE_H264;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    err_count     = 0;
    cycle_count   = 0;
    result_idx    = 0;
    in_stuck      = 1'b0;
    cfg_written   = 1'b0;
    depack_set_mode(MODE_H264);

    phase_mode   = '{MODE_H264, MODE_H265, MODE_PASS, MODE_LEN,
                     MODE_H264, MODE_H265, MODE_H264, MODE_LEN};
    phase_send   = '{0, 46, 0, 32, 46, 0, 32, 0};
    phase_stall  = '{0, 0, 46, 32, 0, 46, 32, 0};
    phase_target = '{60, 30, 30, 30, 60, 30, 60, 30};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_mode(phase_mode[ph]);
      send_idle_pct = phase_send[ph];
      pop_stall_pct = phase_stall[ph];
      if (ph < 4) add_directed(phase_mode[ph]);
      queued_items = 0;
      while (queued_items < phase_target[ph]) begin
        build_packet(phase_mode[ph]);
        send_packet(1'b1, pick_length(phase_mode[ph]), 1'b1);
      end
      // Leaving a packet open checks that the mode write restarts the parser.
      if ($urandom_range(1) == 0) begin
        build_packet(phase_mode[ph]);
        send_packet(1'b0, -1, 1'b0);
      end
      wait_idle();
    end

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
